// ----- hdl/fecs_pkg.sv -----
// Shared types, field widths and constants of the fire cell spread unit.
`default_nettype none

package fecs_pkg;

    // Widths of the transaction fields.
    localparam int CMD_W      = 2;
    localparam int SEL_W      = 2;
    localparam int ADDR_W     = 14;
    localparam int HEAT_W     = 3;
    localparam int FWIDTH_W   = 9;
    localparam int FHEIGHT_W  = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    // Default store geometry.
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 64;

    // Register values after reset and the heat of the source row.
    localparam logic [FWIDTH_W-1:0]  RESET_FRAME_WIDTH  = 9'd80;
    localparam logic [FHEIGHT_W-1:0] RESET_FRAME_HEIGHT = 7'd24;
    localparam logic [HEAT_W-1:0]    SOURCE_HEAT        = 3'd6;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_RESEED = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SPREAD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    // Spread selector codes.
    localparam logic [SEL_W-1:0] SEL_LEFT    = 2'd2;
    localparam logic [SEL_W-1:0] SEL_INVALID = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    // Input transaction.
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [SEL_W-1:0]  rand_sel;
        logic [ADDR_W-1:0] read_addr;
    } t_in_item;

    // Output transaction.
    typedef struct packed {
        logic [HEAT_W-1:0] read_heat;
        logic              write_valid;
        logic [ADDR_W-1:0] write_addr;
        logic [HEAT_W-1:0] write_heat;
        logic              frame_done;
    } t_out_item;

    // Second operand of the shared multiplier.
    typedef enum logic [1:0] {
        MB_ROW,
        MB_HEIGHT,
        MB_HEIGHT_M1
    } t_mul_b;

    // Kind of result loaded into the output register.
    typedef enum logic [1:0] {
        OUT_ZERO,
        OUT_READ,
        OUT_SPREAD
    } t_out_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      capture;
        logic      mul_en;
        t_mul_b    mul_b;
        logic      scan_fix;
        logic      addr_en;
        logic      rd_use_raddr;
        logic      scan_restart;
        logic      sweep;
        logic      load_out;
        t_out_kind out_kind;
    } t_dp_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_last;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- hdl/fecs_cfg.sv -----
// Frame size registers and their clamped working values.
`default_nettype none

module fecs_cfg #(
    parameter int MAX_WIDTH  = fecs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fecs_pkg::DEF_MAX_HEIGHT,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [fecs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [fecs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic [WW-1:0]                      o_width,
    output logic [HW-1:0]                      o_height
);
    import fecs_pkg::*;

    logic [FWIDTH_W-1:0]  r_frame_width;
    logic [FHEIGHT_W-1:0] r_frame_height;

    assign o_cfg_ready = 1'b1;

    // Register writes; the height takes the low bits of the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RESET_FRAME_WIDTH;
            r_frame_height <= RESET_FRAME_HEIGHT;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_FRAME_WIDTH) begin
                r_frame_width <= i_cfg_data;
            end
            if (i_cfg_index == REG_FRAME_HEIGHT) begin
                r_frame_height <= i_cfg_data[FHEIGHT_W-1:0];
            end
        end
    end

    // Clamp the width to one through the store width.
    always_comb begin
        if (r_frame_width == '0) begin
            o_width = WW'(1);
        end else if (int'(r_frame_width) > MAX_WIDTH) begin
            o_width = WW'(MAX_WIDTH);
        end else begin
            o_width = WW'(r_frame_width);
        end
    end

    // Clamp the height to two through the store height.
    always_comb begin
        if (r_frame_height < FHEIGHT_W'(2)) begin
            o_height = HW'(2);
        end else if (int'(r_frame_height) > MAX_HEIGHT) begin
            o_height = HW'(MAX_HEIGHT);
        end else begin
            o_height = HW'(r_frame_height);
        end
    end

endmodule

`default_nettype wire

// ----- hdl/fecs_ctrl.sv -----
// Controller state machine that sequences each command through the datapath.
`default_nettype none

module fecs_ctrl (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  wire  [fecs_pkg::CMD_W-1:0]    i_cmd,
    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output fecs_pkg::t_dp_ctl             o_ctl,
    input  fecs_pkg::t_dp_status          i_status
);
    import fecs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADDR,
        S_SWEEP,
        S_EXEC,
        S_FIN
    } t_state;

    t_state           r_state;
    logic [CMD_W-1:0] r_cmd;
    logic             r_emit;
    logic             r_out_valid;
    logic             out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // Datapath commands for the current state.
    always_comb begin
        o_ctl = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ctl.capture = i_in_valid;
            end
            S_MUL: begin
                o_ctl.mul_en = 1'b1;
                if (r_cmd == CMD_RESEED) begin
                    o_ctl.mul_b = MB_HEIGHT_M1;
                end else if (r_cmd == CMD_READ) begin
                    o_ctl.mul_b = MB_HEIGHT;
                end else begin
                    o_ctl.mul_b = MB_ROW;
                end
                o_ctl.scan_fix = (r_cmd == CMD_SPREAD);
            end
            S_ADDR: begin
                o_ctl.addr_en      = 1'b1;
                o_ctl.rd_use_raddr = (r_cmd == CMD_READ);
                o_ctl.scan_restart = (r_cmd == CMD_RESEED);
            end
            S_SWEEP: begin
                o_ctl.sweep = 1'b1;
            end
            S_EXEC: begin
                o_ctl.load_out = 1'b1;
                if (r_cmd == CMD_SPREAD) begin
                    o_ctl.out_kind = OUT_SPREAD;
                end else if (r_cmd == CMD_READ) begin
                    o_ctl.out_kind = OUT_READ;
                end else begin
                    o_ctl.out_kind = OUT_ZERO;
                end
            end
            S_FIN: begin
                o_ctl.load_out = out_free && r_emit;
                o_ctl.out_kind = OUT_ZERO;
            end
            default: begin
                o_ctl = '0;
            end
        endcase
    end

    // State, latched command and output valid. Reset starts a silent reseed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_MUL;
            r_cmd       <= CMD_RESEED;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ctl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd   <= i_cmd;
                        r_emit  <= 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_ADDR;
                end
                S_ADDR: begin
                    if (r_cmd == CMD_RESEED) begin
                        r_state <= S_SWEEP;
                    end else if (out_free) begin
                        r_state <= S_EXEC;
                    end
                end
                S_SWEEP: begin
                    if (i_status.sweep_last) begin
                        r_state <= S_FIN;
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                end
                S_FIN: begin
                    if (!r_emit || out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hdl/fecs_dp.sv -----
// Datapath: heat memory, scan position, shared multiplier and result register.
`default_nettype none

module fecs_dp #(
    parameter int MAX_WIDTH  = fecs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fecs_pkg::DEF_MAX_HEIGHT,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  fecs_pkg::t_in_item     i_in,
    input  wire  [WW-1:0]          i_width,
    input  wire  [HW-1:0]          i_height,
    input  fecs_pkg::t_dp_ctl      i_ctl,
    output fecs_pkg::t_dp_status   o_status,
    output fecs_pkg::t_out_item    o_out
);
    import fecs_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CLW   = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int PW    = WW + HW;
    localparam int CW    = (AW + 1 > ADDR_W) ? AW + 1 : ADDR_W;

    logic [HEAT_W-1:0] mem [DEPTH];

    logic [SEL_W-1:0]  r_sel;
    logic [ADDR_W-1:0] r_raddr;
    logic [CLW-1:0]    r_col;
    logic [RW-1:0]     r_row;
    logic [PW-1:0]     r_prod;
    logic [AW-1:0]     r_src;
    logic [PW-1:0]     r_base;
    logic [PW:0]       r_end;
    logic [AW-1:0]     r_cnt;
    logic [HEAT_W-1:0] r_rdata;
    t_out_item         r_out;
    t_out_item         n_out;

    logic              scan_bad;
    logic [CLW-1:0]    col_eff;
    logic [RW-1:0]     row_eff;
    logic [HW-1:0]     mul_b_val;
    logic [AW-1:0]     src_calc;
    logic [AW-1:0]     rd_addr;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [HEAT_W-1:0] mem_wdata;
    logic              sweep_in_row;
    logic [SEL_W-1:0]  sel_eff;
    logic [AW:0]       dst;
    logic              dst_ok;
    logic              sp_valid;
    logic [AW-1:0]     sp_addr;
    logic [HEAT_W-1:0] sp_heat;
    logic [RW:0]       row_inc;
    logic [CLW:0]      col_inc;
    logic              row_wrap;
    logic              col_wrap;
    logic              in_frame;
    logic              spread_go;

    // Scan position restarts when it lies outside the current frame.
    assign scan_bad = (WW'(r_col) >= i_width) || (HW'(r_row) >= i_height) || (r_row == '0);
    assign col_eff  = scan_bad ? '0 : r_col;
    assign row_eff  = scan_bad ? RW'(1) : r_row;

    // Operand for the shared multiplier.
    always_comb begin
        unique case (i_ctl.mul_b)
            MB_ROW:       mul_b_val = HW'(row_eff);
            MB_HEIGHT:    mul_b_val = i_height;
            MB_HEIGHT_M1: mul_b_val = i_height - HW'(1);
            default:      mul_b_val = '0;
        endcase
    end

    // Source index and memory read address.
    assign src_calc = AW'(r_prod) + AW'(r_col);
    assign rd_addr  = i_ctl.rd_use_raddr ? AW'(r_raddr) : src_calc;

    // Spread of the source cell into the row above.
    assign sel_eff  = (r_sel == SEL_INVALID) ? SEL_LEFT : r_sel;
    assign dst      = (AW+1)'(r_src) + (AW+1)'(1) - (AW+1)'(sel_eff);
    assign dst_ok   = dst >= (AW+1)'(i_width);
    assign sp_valid = (r_rdata == '0) || dst_ok;
    assign sp_addr  = (r_rdata == '0) ? (r_src - AW'(i_width))
                                      : AW'(dst - (AW+1)'(i_width));
    assign sp_heat  = (r_rdata == '0) ? '0 : (r_rdata - HEAT_W'(sel_eff[0]));
    assign spread_go = i_ctl.load_out && (i_ctl.out_kind == OUT_SPREAD);

    // Scan stepping: rows inner, columns outer.
    assign row_inc  = (RW+1)'(r_row) + (RW+1)'(1);
    assign col_inc  = (CLW+1)'(r_col) + (CLW+1)'(1);
    assign row_wrap = row_inc >= (RW+1)'(i_height);
    assign col_wrap = col_inc >= (CLW+1)'(i_width);

    // Read bound: the product holds the frame area for a read.
    assign in_frame = CW'(r_raddr) < CW'(r_prod);

    // Sweep fills the bottom row of the frame and clears everything else.
    assign sweep_in_row = ((PW+1)'(r_cnt) >= (PW+1)'(r_base)) && ((PW+1)'(r_cnt) < r_end);

    // Memory write port selection.
    always_comb begin
        if (i_ctl.sweep) begin
            mem_we    = 1'b1;
            mem_waddr = r_cnt;
            mem_wdata = sweep_in_row ? SOURCE_HEAT : '0;
        end else begin
            mem_we    = spread_go && sp_valid;
            mem_waddr = sp_addr;
            mem_wdata = sp_heat;
        end
    end

    assign o_status.sweep_last = (r_cnt == AW'(DEPTH - 1));
    assign o_out = r_out;

    // Heat memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[rd_addr];
    end

    // Scan position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= RW'(1);
        end else if (i_ctl.scan_restart) begin
            r_col <= '0;
            r_row <= RW'(1);
        end else if (i_ctl.scan_fix) begin
            r_col <= col_eff;
            r_row <= row_eff;
        end else if (spread_go) begin
            if (row_wrap) begin
                r_row <= RW'(1);
                r_col <= col_wrap ? '0 : CLW'(col_inc);
            end else begin
                r_row <= RW'(row_inc);
            end
        end
    end

    // Captured fields, product, addresses and the sweep counter.
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_sel   <= i_in.rand_sel;
            r_raddr <= i_in.read_addr;
        end
        if (i_ctl.mul_en) begin
            r_prod <= PW'(i_width) * PW'(mul_b_val);
        end
        if (i_ctl.addr_en) begin
            r_src  <= src_calc;
            r_base <= r_prod;
            r_end  <= (PW+1)'(r_prod) + (PW+1)'(i_width);
            r_cnt  <= '0;
        end else if (i_ctl.sweep) begin
            r_cnt <= r_cnt + AW'(1);
        end
    end

    // Result of the current command; fields it does not produce stay zero.
    always_comb begin
        n_out = '0;
        unique case (i_ctl.out_kind)
            OUT_ZERO: begin
                n_out = '0;
            end
            OUT_READ: begin
                n_out.read_heat = in_frame ? r_rdata : '0;
            end
            OUT_SPREAD: begin
                n_out.write_valid = sp_valid;
                n_out.write_addr  = sp_valid ? ADDR_W'(sp_addr) : '0;
                n_out.write_heat  = sp_valid ? sp_heat : '0;
                n_out.frame_done  = row_wrap && col_wrap;
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/fire_effect_cell_spread_unit.sv -----
// Top level of the fire cell spread unit: size registers, controller and datapath.
//
//  Channel  Direction  Handshake            Contents
//  in       to block   i_in_valid/o_in_stall    cmd, rand_sel, read_addr
//  out      from block o_out_valid/i_out_stall  read_heat, write_valid, write_addr,
//                                               write_heat, frame_done
//  cfg      to block   i_cfg_valid/o_cfg_ready  register index, write data
//
// A spread, read or unused command steps through capture, multiply (scan row times
// width, or the frame area), memory read, then the write-back and result load. The
// next command is accepted only after the result load, which waits while a stalled
// result still holds the output register. A reseed sweeps the whole store, one
// memory entry written per cycle. After reset the same sweep runs with no result;
// no command is accepted until it ends.
// A stalled result holds in the output register while the next command is accepted.
`default_nettype none

module fire_effect_cell_spread_unit #(
    parameter int MAX_WIDTH  = fecs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fecs_pkg::DEF_MAX_HEIGHT
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  fecs_pkg::t_in_item               i_in_data,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output fecs_pkg::t_out_item              o_out_data,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [fecs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [fecs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import fecs_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [WW-1:0] width_used;
    logic [HW-1:0] height_used;
    t_dp_ctl       dp_ctl;
    t_dp_status    dp_status;

    // Frame size registers.
    fecs_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_width     (width_used),
        .o_height    (height_used)
    );

    // Command sequencing.
    fecs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_in_data.cmd),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_ctl       (dp_ctl),
        .i_status    (dp_status)
    );

    // Heat memory and arithmetic.
    fecs_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in_data),
        .i_width  (width_used),
        .i_height (height_used),
        .i_ctl    (dp_ctl),
        .o_status (dp_status),
        .o_out    (o_out_data)
    );

endmodule

`default_nettype wire

// ----- bench/fecs_spread_checker.sv -----
// Checker of the fire cell spread unit: watches the channels, predicts every result and compares.
`default_nettype none

module fecs_spread_checker (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    input  wire                              i_in_stall,
    input  fecs_pkg::t_in_item               i_in_data,
    input  wire                              i_out_valid,
    input  wire                              i_out_stall,
    input  fecs_pkg::t_out_item              i_out_data,
    input  wire                              i_cfg_valid,
    input  wire                              i_cfg_ready,
    input  wire  [fecs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [fecs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                               o_pending,
    output int                               o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import fecs_pkg::*;

    localparam int STORE_CELLS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    // Beyond this many reported mismatches only the count goes on.
    localparam int REPORT_CAP  = 100;

    // Predicted state of the block.
    logic [HEAT_W-1:0]    cell_heat [STORE_CELLS];
    logic [FWIDTH_W-1:0]  width_reg;
    logic [FHEIGHT_W-1:0] height_reg;
    int unsigned          scan_col;
    int unsigned          scan_row;

    // Results still owed by the block, oldest first.
    fecs_pkg::t_out_item  owed_results [$];
    int                   mismatches;

    // Frame sizes as the block uses them, clamped to the store.
    function automatic int unsigned live_width();
        if (width_reg == '0) return 1;
        if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned live_height();
        if (height_reg < 2) return 2;
        if (height_reg > DEF_MAX_HEIGHT) return DEF_MAX_HEIGHT;
        return height_reg;
    endfunction

    // Clear the store, light the bottom row and restart the scan.
    function automatic void reseed_frame();
        int unsigned w;
        int unsigned h;
        w = live_width();
        h = live_height();
        for (int i = 0; i < STORE_CELLS; i++) begin
            cell_heat[i] = '0;
        end
        for (int unsigned c = 0; c < w; c++) begin
            cell_heat[(h - 1) * w + c] = SOURCE_HEAT;
        end
        scan_col = 0;
        scan_row = 1;
    endfunction

    // Apply one command to the predicted frame and return the result it causes.
    function automatic fecs_pkg::t_out_item advance_fire(input fecs_pkg::t_in_item item);
        fecs_pkg::t_out_item res;
        int unsigned         w;
        int unsigned         h;
        int unsigned         src;
        int unsigned         dst;
        logic [SEL_W-1:0]    sel;
        logic [HEAT_W-1:0]   heat;
        res = '0;
        w = live_width();
        h = live_height();
        case (item.cmd)
            CMD_RESEED: begin
                reseed_frame();
            end
            CMD_SPREAD: begin
                // A size change can leave the scan outside the frame.
                if (scan_col >= w || scan_row >= h || scan_row < 1) begin
                    scan_col = 0;
                    scan_row = 1;
                end
                sel = (item.rand_sel == SEL_INVALID) ? SEL_LEFT : item.rand_sel;
                src = scan_row * w + scan_col;
                heat = cell_heat[src];
                if (heat == '0) begin
                    // A cold cell cools the one straight above it.
                    res.write_valid = 1'b1;
                    res.write_addr  = src - w;
                    res.write_heat  = '0;
                end else begin
                    // The target wraps across row ends; nothing lands above the top row.
                    dst = src + 1 - sel;
                    if (dst >= w) begin
                        res.write_valid = 1'b1;
                        res.write_addr  = dst - w;
                        res.write_heat  = heat - sel[0];
                    end
                end
                if (res.write_valid) begin
                    cell_heat[res.write_addr] = res.write_heat;
                end
                scan_row++;
                if (scan_row >= h) begin
                    scan_row = 1;
                    scan_col++;
                    if (scan_col >= w) begin
                        scan_col = 0;
                        res.frame_done = 1'b1;
                    end
                end
            end
            CMD_READ: begin
                if (item.read_addr < w * h) begin
                    res.read_heat = cell_heat[item.read_addr];
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic compare_field(input string field, input logic [ADDR_W-1:0] want,
                                 input logic [ADDR_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_CAP) begin
                $display("time %0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
            end
        end
    endtask

    // Configuration writes, then the outgoing transaction, then the incoming one.
    always @(posedge i_clk) begin : monitor
        fecs_pkg::t_out_item want;
        if (!i_rst_n) begin
            width_reg  = RESET_FRAME_WIDTH;
            height_reg = RESET_FRAME_HEIGHT;
            reseed_frame();
            owed_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_FRAME_WIDTH) begin
                    width_reg = i_cfg_data[FWIDTH_W-1:0];
                end else begin
                    height_reg = i_cfg_data[FHEIGHT_W-1:0];
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP) begin
                        $display("time %0t: result with none expected, expected none, actual %h",
                                 $time, i_out_data);
                    end
                end else begin
                    want = owed_results.pop_front();
                    compare_field("read_heat",   want.read_heat,   i_out_data.read_heat);
                    compare_field("write_valid", want.write_valid, i_out_data.write_valid);
                    compare_field("write_addr",  want.write_addr,  i_out_data.write_addr);
                    compare_field("write_heat",  want.write_heat,  i_out_data.write_heat);
                    compare_field("frame_done",  want.frame_done,  i_out_data.frame_done);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                owed_results.push_back(advance_fire(i_in_data));
            end
        end
        o_pending    <= owed_results.size();
        o_mismatches <= mismatches;
    end

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Testbench top of the fire cell spread unit: clock, reset, stimulus, stalls and verdict.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fecs_pkg::*;

    localparam int RESET_CYCLES = 11;
    localparam int ITEM_TARGET  = 850;
    localparam int BURST_ITEMS  = 40;
    // Long receiver hold-off that backs the block up into its input.
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 8;
    // A reseed or the clearing pass after reset runs with no channel moving a transaction.
    localparam int QUIET_LIMIT  = 100000;
    localparam int IN_PHASE_RESEED_PERMILLE = 4;
    localparam logic [SEL_W-1:0] SEL_RIGHT = 2'd0;
    localparam logic [SEL_W-1:0] SEL_UP    = 2'd1;
    localparam logic [ADDR_W-1:0] ADDR_TOP = '1;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    t_in_item               i_in_data;
    logic                   o_out_valid;
    logic                   i_out_stall;
    t_out_item              o_out_data;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    int                     pending;
    int                     mismatch_count;
    int                     items_sent;
    int                     cur_w;
    int                     cur_h;
    int                     gap_mode;
    bit                     hold_req;

    fire_effect_cell_spread_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    fecs_spread_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_mismatches (mismatch_count)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap(input int mode);
        int r;
        if (mode == 0) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_item make_item(input logic [CMD_W-1:0] cmd,
                                           input logic [SEL_W-1:0] sel,
                                           input logic [ADDR_W-1:0] addr);
        t_in_item item;
        item.cmd       = cmd;
        item.rand_sel  = sel;
        item.read_addr = addr;
        return item;
    endfunction

    // Mostly spreads and reads inside the frame, some reads anywhere in the store.
    function automatic t_in_item random_command(input int reseed_permille);
        t_in_item item;
        int       r;
        item.rand_sel = $urandom_range(0, 3);
        if ($urandom_range(0, 9) < 7) begin
            item.read_addr = $urandom_range(0, cur_w * cur_h - 1);
        end else begin
            item.read_addr = $urandom_range(0, ADDR_TOP);
        end
        r = $urandom_range(0, 999);
        if (r < reseed_permille) item.cmd = CMD_RESEED;
        else if (r < 30) item.cmd = CMD_NONE;
        else if (r < 320) item.cmd = CMD_READ;
        else item.cmd = CMD_SPREAD;
        return item;
    endfunction

    task automatic idle_input(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    // Offer one transaction after an optional gap and hold it until accepted.
    task automatic send_item(input t_in_item item, input int gap);
        idle_input(gap);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // Stop offering and wait until every owed result has been taken.
    task automatic drain_results();
        idle_input(1);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Both size registers; the local copy of the clamped sizes steers read addresses.
    task automatic write_sizes(input logic [CFG_DATA_W-1:0] w_data,
                               input logic [CFG_DATA_W-1:0] h_data);
        cfg_write(REG_FRAME_WIDTH, w_data);
        cfg_write(REG_FRAME_HEIGHT, h_data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_w = (w_data == 0) ? 1 : ((w_data > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(w_data));
        cur_h = (h_data[FHEIGHT_W-1:0] < 2) ? 2 :
                ((h_data[FHEIGHT_W-1:0] > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT :
                 int'(h_data[FHEIGHT_W-1:0]));
    endtask

    // One stretch of random traffic at one frame size.
    task automatic run_phase(input logic [CFG_DATA_W-1:0] w_data,
                             input logic [CFG_DATA_W-1:0] h_data,
                             input bit reseed_first, input int count);
        drain_results();
        write_sizes(w_data, h_data);
        gap_mode = $urandom_range(0, 2);
        if (reseed_first) begin
            send_item(make_item(CMD_RESEED, $urandom_range(0, 3), $urandom_range(0, ADDR_TOP)),
                      0);
        end
        repeat (count) begin
            send_item(random_command(IN_PHASE_RESEED_PERMILLE), pick_gap(gap_mode));
        end
    endtask

    // Receiver: random stalls, stretches without any, and one long hold-off on request.
    initial begin : receiver
        int  free_left;
        int  stall_left;
        bit  hold_done;
        i_out_stall = 1'b0;
        free_left   = 0;
        stall_left  = 0;
        hold_done   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
                free_left  = 0;
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
                if (free_left > 0) begin
                    free_left--;
                end else begin
                    free_left  = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 120)
                                                             : $urandom_range(0, 4);
                    stall_left = pick_gap(1);
                end
            end
        end
    end

    // Watchdog on cycles in which no channel moves a transaction.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stimulus and verdict.
    initial begin : stimulus
        logic [CFG_DATA_W-1:0] w_data;
        logic [CFG_DATA_W-1:0] h_data;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        items_sent  = 0;
        cur_w       = RESET_FRAME_WIDTH;
        cur_h       = RESET_FRAME_HEIGHT;
        gap_mode    = 1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset frame: source row edges, reads past the frame, the unused command,
        // a cold cell and the out-of-range selector.
        send_item(make_item(CMD_READ, SEL_RIGHT, 14'd1840), 0);
        send_item(make_item(CMD_READ, SEL_RIGHT, 14'd1919), pick_gap(gap_mode));
        send_item(make_item(CMD_READ, SEL_RIGHT, 14'd1920), pick_gap(gap_mode));
        send_item(make_item(CMD_READ, SEL_INVALID, ADDR_TOP), pick_gap(gap_mode));
        send_item(make_item(CMD_NONE, SEL_INVALID, ADDR_TOP), pick_gap(gap_mode));
        send_item(make_item(CMD_SPREAD, SEL_RIGHT, '0), pick_gap(gap_mode));
        send_item(make_item(CMD_SPREAD, SEL_INVALID, '0), pick_gap(gap_mode));

        // Three by two frame: scan left outside the frame, then every spread direction,
        // a left spread that falls off the top, the row wrap and the frame end.
        drain_results();
        write_sizes(9'd3, 9'd2);
        send_item(make_item(CMD_SPREAD, SEL_UP, '0), 0);
        send_item(make_item(CMD_RESEED, SEL_RIGHT, '0), pick_gap(gap_mode));
        send_item(make_item(CMD_SPREAD, SEL_RIGHT, '0), pick_gap(gap_mode));
        send_item(make_item(CMD_SPREAD, SEL_UP, '0), pick_gap(gap_mode));
        send_item(make_item(CMD_SPREAD, SEL_LEFT, '0), pick_gap(gap_mode));
        send_item(make_item(CMD_SPREAD, SEL_LEFT, '0), pick_gap(gap_mode));
        send_item(make_item(CMD_SPREAD, SEL_INVALID, '0), pick_gap(gap_mode));
        send_item(make_item(CMD_SPREAD, SEL_RIGHT, '0), pick_gap(gap_mode));
        send_item(make_item(CMD_READ, SEL_RIGHT, 14'd0), pick_gap(gap_mode));
        send_item(make_item(CMD_READ, SEL_RIGHT, 14'd1), pick_gap(gap_mode));
        send_item(make_item(CMD_READ, SEL_RIGHT, 14'd5), pick_gap(gap_mode));
        send_item(make_item(CMD_READ, SEL_RIGHT, 14'd6), pick_gap(gap_mode));

        // Back-to-back traffic while the receiver holds off, so the block backs up.
        hold_req = 1'b1;
        repeat (BURST_ITEMS) send_item(random_command(0), 0);

        // Size extremes, including values that get clamped or masked.
        run_phase(9'd256, 9'd64, 1'b1, 90);
        run_phase(9'd0, 9'h180, 1'b1, 70);
        run_phase(9'd511, 9'd127, 1'b0, 70);
        run_phase(9'd1, 9'h101, 1'b1, 60);
        run_phase(9'd255, 9'd63, 1'b1, 110);

        // Random sizes, mostly small frames so that scans wrap often.
        while (items_sent < ITEM_TARGET) begin
            w_data = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                                 : 9'($urandom_range(1, 12));
            h_data = 9'($urandom_range(0, 3) << FHEIGHT_W);
            h_data = h_data | (($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 127))
                                                           : 9'($urandom_range(2, 8)));
            run_phase(w_data, h_data, $urandom_range(0, 4) < 3, $urandom_range(50, 90));
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
